### rtl/core/adjacency_matrix_reachability_assert.svh
// Assertion macros for the checker files of the reachability block.
`ifndef ADJACENCY_MATRIX_REACHABILITY_ASSERT_SVH
`define ADJACENCY_MATRIX_REACHABILITY_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define AMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define AMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/amr_pkg.sv
// Shared types and constants of the adjacency matrix reachability block.
package amr_pkg;

    localparam int unsigned VERT_W      = 5;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned TOTAL_W     = 9;
    localparam int unsigned CFG_W       = 6;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PATH   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SELF   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd4;

    localparam logic [1:0] FND_ZERO = 2'd0;
    localparam logic [1:0] FND_EDGE = 2'd1;
    localparam logic [1:0] FND_PATH = 2'd2;

    typedef struct packed {
        logic                load;
        logic                rd_a;
        logic                rd_b;
        logic                wr_a;
        logic                wr_b;
        logic                walk_start;
        logic                walk_step;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_found;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
    } amr_cmd_t;

    typedef struct packed {
        logic              in_range;
        logic              self_loop;
        logic [MODE_W-1:0] mode;
        logic              edge_bit;
        logic              walk_done;
        logic              out_free;
    } amr_sts_t;

endpackage

### rtl/core/amr_ram.sv
// Generic simple dual-port RAM with registered read data.
module amr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/amr_ctrl.sv
// Controller state machine of the reachability block.
module amr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  amr_pkg::amr_sts_t  sts,
    output amr_pkg::amr_cmd_t  cmd
);

    import amr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_WRB    = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.in_range)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_RANGE;
                    cmd.res_found  = FND_ZERO;
                    state_next     = S_FIN;
                end
                else if (sts.mode == MODE_PATH)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.res_set   = 1'b1;
                cmd.res_found = FND_ZERO;
                state_next    = S_FIN;
                priority if (sts.mode == MODE_ADD)
                begin
                    if (sts.edge_bit)
                    begin
                        cmd.res_status = ST_DUP;
                    end
                    else if (sts.self_loop)
                    begin
                        cmd.res_status = ST_SELF;
                    end
                    else
                    begin
                        cmd.res_status = ST_OK;
                        cmd.wr_a       = 1'b1;
                        cmd.rd_b       = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        state_next     = S_WRB;
                    end
                end
                else if (sts.mode == MODE_REMOVE)
                begin
                    if (!sts.edge_bit)
                    begin
                        cmd.res_status = ST_ABSENT;
                    end
                    else
                    begin
                        cmd.res_status = ST_OK;
                        cmd.wr_a       = 1'b1;
                        cmd.rd_b       = 1'b1;
                        cmd.cnt_dec    = 1'b1;
                        state_next     = S_WRB;
                    end
                end
                else
                begin
                    cmd.res_status = ST_OK;
                    cmd.res_found  = FND_EDGE;
                end
            end
            S_WRB:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_FIN;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_found  = FND_PATH;
                    state_next     = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/amr_datapath.sv
// Datapath of the reachability block: adjacency RAM, walk masks, counter, result.
module amr_datapath #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [amr_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [amr_pkg::MODE_W-1:0]      in_mode,
    input  logic [amr_pkg::VERT_W-1:0]      in_a,
    input  logic [amr_pkg::VERT_W-1:0]      in_b,
    input  amr_pkg::amr_cmd_t               cmd,
    output amr_pkg::amr_sts_t               sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [amr_pkg::STATUS_W-1:0]    out_status,
    output logic                            out_found,
    output logic [amr_pkg::TOTAL_W-1:0]     out_total
);

    import amr_pkg::*;

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned CW = (NW > VERT_W) ? NW : VERT_W;
    localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

    logic [CFG_W-1:0]        vcount_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [VERT_W-1:0]       a_reg;
    logic [VERT_W-1:0]       b_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic                    rd_valid_next;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] visited_next;
    logic [MAX_VERTICES-1:0] pending_reg;
    logic [MAX_VERTICES-1:0] pending_next;
    logic                    rd_pend_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic                    found_reg;
    logic                    found_next;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_found_reg;
    logic [TOTAL_W-1:0]      out_total_reg;

    logic [NW-1:0]           n_active;
    logic [MAX_VERTICES-1:0] live;
    logic [AW-1:0]           a_idx;
    logic [AW-1:0]           b_idx;
    logic [AW-1:0]           pick_idx;
    logic                    pending_any;
    logic                    walk_rd;
    logic [MAX_VERTICES-1:0] new_bits;
    logic [MAX_VERTICES-1:0] ram_rdata;
    logic [MAX_VERTICES-1:0] rd_row;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [MAX_VERTICES-1:0] ram_wdata;
    logic                    set_val;

    assign a_idx = AW'(a_reg);
    assign b_idx = AW'(b_reg);

    // Active vertex count saturates at the matrix size.
    always_comb
    begin
        if (vcount_reg > MAX_VERTICES)
        begin
            n_active = NW'(MAX_VERTICES);
        end
        else
        begin
            n_active = NW'(vcount_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            live[i] = (NW'(i) < n_active);
        end
    end

    // Rows never written read as empty.
    assign rd_row = ram_rdata & {MAX_VERTICES{rd_valid_reg}};

    // Lowest vertex still waiting for expansion.
    always_comb
    begin
        pick_idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                pick_idx = AW'(i);
            end
        end
    end

    assign pending_any = |pending_reg;
    assign walk_rd     = cmd.walk_step && pending_any;
    assign new_bits    = rd_pend_reg ? (rd_row & live & ~visited_reg) : '0;

    always_comb
    begin
        ram_re = cmd.rd_a || cmd.rd_b || walk_rd;
        priority if (cmd.rd_a)
        begin
            ram_raddr = a_idx;
        end
        else if (cmd.rd_b)
        begin
            ram_raddr = b_idx;
        end
        else
        begin
            ram_raddr = pick_idx;
        end
    end

    // Write back the row just read with one bit set for add, cleared for remove.
    always_comb
    begin
        set_val   = (mode_reg == MODE_ADD);
        ram_we    = cmd.wr_a || cmd.wr_b;
        ram_waddr = cmd.wr_a ? a_idx : b_idx;
        ram_wdata = rd_row;
        if (cmd.wr_a)
        begin
            ram_wdata[b_idx] = set_val;
        end
        else
        begin
            ram_wdata[a_idx] = set_val;
        end
    end

    amr_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_amr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        visited_next  = visited_reg;
        pending_next  = pending_reg;
        rd_valid_next = rd_valid_reg;
        if (ram_re)
        begin
            rd_valid_next = row_valid_reg[ram_raddr];
        end
        if (cmd.walk_start)
        begin
            visited_next = ONE << a_idx;
            pending_next = ONE << a_idx;
        end
        else if (cmd.walk_step)
        begin
            visited_next = visited_reg | new_bits;
            pending_next = (pending_reg & ~(walk_rd ? (ONE << pick_idx) : '0)) | new_bits;
        end
    end

    always_comb
    begin
        unique case (cmd.res_found)
            FND_EDGE: found_next = rd_row[b_idx];
            FND_PATH: found_next = visited_reg[b_idx];
            default:  found_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= CFG_RESET;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            visited_reg   <= '0;
            pending_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            rd_valid_reg <= rd_valid_next;
            visited_reg  <= visited_next;
            pending_reg  <= pending_next;
            rd_pend_reg  <= walk_rd;
            if (cmd.cnt_inc)
            begin
                total_reg <= total_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                total_reg <= total_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            a_reg    <= in_a;
            b_reg    <= in_b;
        end
        if (cmd.res_set)
        begin
            status_reg <= cmd.res_status;
            found_reg  <= found_next;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
            out_total_reg  <= total_reg;
        end
    end

    always_comb
    begin
        sts.in_range  = (CW'(a_reg) < CW'(n_active)) && (CW'(b_reg) < CW'(n_active));
        sts.self_loop = (a_reg == b_reg);
        sts.mode      = mode_reg;
        sts.edge_bit  = rd_row[b_idx];
        sts.walk_done = !pending_any && !rd_pend_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_total  = out_total_reg;

endmodule

### rtl/core/adjacency_matrix_reachability.sv
// Top level of the undirected graph adjacency matrix and reachability block.
//
//  channel   | group                       | contents (lowest bit first)
//  ----------+-----------------------------+-----------------------------------------
//  request   | s_axis_tvalid/tready/...    | tuser: mode; tdata: vertex_a, vertex_b
//  result    | m_axis_tvalid/tready/tdata  | tdata: status, found, edge_total
//  config    | cfg_wr_en, cfg_wr_data      | vertex_count, written on any enabled edge
//
// One request word is in flight at a time. A range refusal goes from decode
// straight to the final state; edge queries and refused adds or removes read row a;
// successful adds and removes read row a, write it and read row b, then write row b.
// A path query reads one row per cycle, but a row must land before the vertices it
// adds can be picked, so along a chain each read waits for the row before it.
// Reset clears the graph at once through per-row valid bits, so the block takes
// words right after reset. A finished result waits in the output register while
// the next request word is accepted; a stalled result holds the block in its final
// state until the result word is taken.
module adjacency_matrix_reachability #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // vertex_count register
    input  logic                                cfg_wr_en,
    input  logic [amr_pkg::CFG_W-1:0]           cfg_wr_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [amr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [4:0] vertex_a, [9:5] vertex_b
    input  logic [amr_pkg::MODE_W-1:0]          s_axis_tuser,   // [1:0] mode
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [amr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // [2:0] status, [3] found,
                                                                // [12:4] edge_total
);

    import amr_pkg::*;

    amr_cmd_t            cmd;
    amr_sts_t            sts;
    logic [STATUS_W-1:0] out_status;
    logic                out_found;
    logic [TOTAL_W-1:0]  out_total;

    // Sequence each request word through read, check, write-back or walk.
    amr_ctrl u_amr_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the matrix, edge counter, walk masks and the result register.
    amr_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_amr_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mode     (s_axis_tuser),
        .in_a        (s_axis_tdata[VERT_W-1:0]),
        .in_b        (s_axis_tdata[2*VERT_W-1:VERT_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (out_status),
        .out_found   (out_found),
        .out_total   (out_total)
    );

    // Pack the result word, zero fill to whole bytes.
    assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - 1 - TOTAL_W){1'b0}},
                           out_total, out_found, out_status};

endmodule

### rtl/core/amr_checker.sv
// Port-level checker of the reachability block and its bind.
`include "adjacency_matrix_reachability_assert.svh"

module amr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [amr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [amr_pkg::MODE_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [amr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import amr_pkg::*;

    // A stalled result word holds.
    `AMR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // One request word at a time: ready drops after an accept.
    `AMR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

    // No result can appear in the cycle right after an accept.
    `AMR_ASSERT_NEXT(a_no_early_result, clk, rst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result rose one cycle after accept")

    // A found flag only comes with an ok status.
    `AMR_ASSERT_IMPL(a_found_ok, clk, rst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == ST_OK, "found set with a refusal status")

endmodule

bind adjacency_matrix_reachability amr_checker u_amr_checker (.*);

### bench/adjacency_matrix_reachability_checker.sv
`timescale 1ns / 100ps
// Checker that mirrors the graph state and compares every result word of the block.
module adjacency_matrix_reachability_checker #(
    parameter int unsigned MAX_VERTICES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [amr_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [amr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [4:0] vertex_a, [9:5] vertex_b
    input  logic [amr_pkg::MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [amr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] status, [3] found,
                                                            // [12:4] edge_total
    output int unsigned                     pending_words,
    output int unsigned                     mismatch_count
);
    import amr_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [TOTAL_W-1:0]  edge_total;
    } answer_t;

    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    logic [TOTAL_W-1:0]      edge_tally;
    logic [CFG_W-1:0]        vertex_limit;
    answer_t                 answer_q [$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 40)
            $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Breadth-first walk over live vertices; a vertex always reaches itself.
    function automatic logic walk_reaches(input logic [VERT_W-1:0] va,
                                          input logic [VERT_W-1:0] vb,
                                          input int unsigned n);
        logic [MAX_VERTICES-1:0] live;
        logic [MAX_VERTICES-1:0] seen;
        logic [MAX_VERTICES-1:0] front;
        logic [MAX_VERTICES-1:0] nxt;
        int unsigned             u;
        live = (n >= MAX_VERTICES) ? '1 : ((MAX_VERTICES)'(1) << n) - 1'b1;
        seen = (MAX_VERTICES)'(1) << va;
        front = seen;
        while (front != '0)
        begin
            nxt = '0;
            for (u = 0; u < n; u++)
                if (front[u])
                    nxt |= adj_rows[u];
            nxt &= live & ~seen;
            seen |= nxt;
            front = nxt;
        end
        return seen[vb];
    endfunction

    task automatic apply_request(input logic [MODE_W-1:0] mode,
                                 input logic [VERT_W-1:0] va,
                                 input logic [VERT_W-1:0] vb,
                                 output answer_t ans);
        int unsigned n;
        n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : 32'(vertex_limit);
        ans.status = ST_OK;
        ans.found = 1'b0;
        if (va >= n || vb >= n)
            ans.status = ST_RANGE;
        else
        begin
            case (mode)
                MODE_ADD:
                    if (adj_rows[va][vb])
                        ans.status = ST_DUP;
                    else if (va == vb)
                        ans.status = ST_SELF;
                    else
                    begin
                        adj_rows[va][vb] = 1'b1;
                        adj_rows[vb][va] = 1'b1;
                        edge_tally = edge_tally + 1'b1;
                    end
                MODE_REMOVE:
                    if (!adj_rows[va][vb])
                        ans.status = ST_ABSENT;
                    else
                    begin
                        adj_rows[va][vb] = 1'b0;
                        adj_rows[vb][va] = 1'b0;
                        edge_tally = edge_tally - 1'b1;
                    end
                MODE_EDGE:
                    ans.found = adj_rows[va][vb];
                MODE_PATH:
                    ans.found = walk_reaches(va, vb, n);
            endcase
        end
        ans.edge_total = edge_tally;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t     want;
        answer_t     got;
        int unsigned pend;
        int unsigned r;
        if (!rst_n)
        begin
            for (r = 0; r < MAX_VERTICES; r++)
                adj_rows[r] = '0;
            edge_tally = '0;
            vertex_limit = CFG_RESET;
            answer_q.delete();
            pending_words <= 0;
            mismatch_count = 0;
        end
        else
        begin
            pend = pending_words;
            if (cfg_wr_en)
                vertex_limit = cfg_wr_data;
            // Retire before predicting: a word leaving now belongs to an older request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[STATUS_W-1:0];
                got.found = m_axis_tdata[STATUS_W];
                got.edge_total = m_axis_tdata[STATUS_W+1 +: TOTAL_W];
                if (answer_q.size() == 0)
                    report_mismatch("result word with nothing pending", 32'(m_axis_tdata), 0);
                else
                begin
                    want = answer_q.pop_front();
                    pend = pend - 1;
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.found !== want.found)
                        report_mismatch("found", 32'(got.found), 32'(want.found));
                    if (got.edge_total !== want.edge_total)
                        report_mismatch("edge_total", 32'(got.edge_total),
                                        32'(want.edge_total));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(s_axis_tuser, s_axis_tdata[VERT_W-1:0],
                              s_axis_tdata[2*VERT_W-1:VERT_W], want);
                answer_q.push_back(want);
                pend = pend + 1;
            end
            pending_words <= pend;
        end
    end

endmodule

### bench/tb_adjacency_matrix_reachability.sv
`timescale 1ns / 100ps
// Top of the reachability block testbench: clock, reset, request stimulus and verdict.
module tb_adjacency_matrix_reachability;
    import amr_pkg::*;

    localparam int unsigned MAX_VERTICES = 32;
    localparam int unsigned RANDOM_WORDS = 1550;
    // Slowest word: long sender gap + path walk + long receiver stall;
    // take the limit many times over.
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TAIL_CYCLES  = 2 * MAX_VERTICES + 8;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;    // [4:0] vertex_a, [9:5] vertex_b
    logic [MODE_W-1:0]      s_axis_tuser;    // [1:0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;    // [2:0] status, [3] found, [12:4] edge_total

    int unsigned pending_words;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    // Calm phases run both sides without any gaps.
    logic        calm;

    adjacency_matrix_reachability #(
        .MAX_VERTICES (MAX_VERTICES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    adjacency_matrix_reachability_checker #(
        .MAX_VERTICES (MAX_VERTICES)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Result side: stall tready for random stretches, never while calm.
    initial
    begin : result_sink
        int unsigned stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                stall = stall - 1;
            end
            else
            begin
                stall = calm ? 0 : pick_gap();
                m_axis_tready <= (stall == 0);
                if (stall != 0)
                    stall = stall - 1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("[adjacency_matrix_reachability] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one request word and hold it until the block takes it. Keep tvalid
    // high on return so a back-to-back word needs no second assignment.
    task automatic send_word(input logic [MODE_W-1:0] mode,
                             input logic [VERT_W-1:0] va,
                             input logic [VERT_W-1:0] vb);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - 2 * VERT_W){1'b0}}, vb, va};
        s_axis_tuser <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop tvalid and hold until every predicted result word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    // Write vertex_count only once the block is idle.
    task automatic set_vertex_count(input logic [CFG_W-1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Random request: mostly live vertices so the graph fills and walks go deep,
    // the rest anywhere in the 5-bit range to hit range refusals.
    task automatic send_random_word(input int unsigned live_n);
        logic [MODE_W-1:0] mode;
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
        int unsigned       roll;
        roll = $urandom_range(99, 0);
        if (roll < 35)
            mode = MODE_ADD;
        else if (roll < 55)
            mode = MODE_REMOVE;
        else if (roll < 70)
            mode = MODE_EDGE;
        else
            mode = MODE_PATH;
        if (live_n != 0 && $urandom_range(9, 0) != 0)
        begin
            va = VERT_W'($urandom_range(live_n - 1, 0));
            vb = VERT_W'($urandom_range(live_n - 1, 0));
        end
        else
        begin
            va = VERT_W'($urandom_range(31, 0));
            vb = VERT_W'($urandom_range(31, 0));
        end
        send_word(mode, va, vb);
    endtask

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned phase_len;
        int unsigned setting;
        int unsigned live_n;
        int unsigned k;
        int unsigned roll;

        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= CFG_RESET;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= MODE_ADD;
        calm <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset count of 32 vertices.
        send_word(MODE_ADD, 0, 31);        // plain add at the extremes
        send_word(MODE_ADD, 31, 0);        // existing edge, reversed endpoints
        send_word(MODE_ADD, 5, 5);         // self-loop add is refused
        send_word(MODE_REMOVE, 5, 5);      // self-loop is never present
        send_word(MODE_EDGE, 5, 5);
        send_word(MODE_EDGE, 0, 31);
        send_word(MODE_EDGE, 31, 1);
        send_word(MODE_PATH, 7, 7);        // a vertex reaches itself
        send_word(MODE_ADD, 31, 16);
        send_word(MODE_ADD, 16, 10);
        send_word(MODE_PATH, 0, 10);       // reachable over a chain
        send_word(MODE_PATH, 10, 0);
        send_word(MODE_PATH, 0, 3);        // unreachable
        send_word(MODE_REMOVE, 2, 3);      // remove of an absent edge
        send_word(MODE_REMOVE, 16, 31);
        send_word(MODE_PATH, 0, 10);       // chain now broken

        // Zero count: every vertex is out of range.
        set_vertex_count(0);
        send_word(MODE_ADD, 0, 0);
        send_word(MODE_PATH, 0, 0);

        // Lowered count: edges to vertex 31 stay counted but are never walked.
        set_vertex_count(16);
        send_word(MODE_EDGE, 0, 31);
        send_word(MODE_REMOVE, 0, 31);
        send_word(MODE_PATH, 10, 0);

        set_vertex_count(1);
        send_word(MODE_PATH, 0, 0);
        send_word(MODE_ADD, 0, 1);

        set_vertex_count(32);
        send_word(MODE_PATH, 0, 31);

        // Random phases, each at its own vertex count.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 20)
                setting = 32;
            else if (roll < 30)
                setting = $urandom_range(2, 0);
            else
                setting = $urandom_range(16, 3);
            set_vertex_count(CFG_W'(setting));
            live_n = (setting > MAX_VERTICES) ? MAX_VERTICES : setting;
            calm <= ($urandom_range(4, 0) == 0);
            phase_len = $urandom_range(150, 40);
            for (k = 0; k < phase_len && sent < RANDOM_WORDS; k++)
            begin
                // Now and then hold the sender until the block runs dry.
                if ($urandom_range(99, 0) == 0)
                    drain();
                send_random_word(live_n);
                sent = sent + 1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("[adjacency_matrix_reachability] OK");
        else
            $display("[adjacency_matrix_reachability] ERROR");
        $finish;
    end

endmodule
